FILE: hdl/plsup_pkg.sv
// Shared types and codes for the process lifecycle supervisor.
// No dependencies; imported by every module of the block.
package plsup_pkg;

    localparam int NowW      = 63;
    localparam int WindowW   = 32;
    localparam int CountW    = 8;
    localparam int MsgIdW    = 32;
    localparam int KindW     = 3;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 32;
    localparam int InDataW   = 104;   // 97 payload bits padded to whole bytes
    localparam int OutDataW  = 16;    // 15 payload bits padded to whole bytes

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    typedef enum logic [1:0] {
        ST_STOPPED = 2'd0,
        ST_UNREG   = 2'd1,
        ST_REG     = 2'd2
    } lc_state_t;

    typedef enum logic [2:0] {
        OC_NONE    = 3'd0,
        OC_STATUS  = 3'd1,
        OC_DIED    = 3'd2,
        OC_PAUSE   = 3'd3,
        OC_TERM    = 3'd4,
        OC_ILLEGAL = 3'd5
    } outcome_t;

    localparam logic [KindW-1:0] EV_START   = 3'd0;
    localparam logic [KindW-1:0] EV_DIED    = 3'd1;
    localparam logic [KindW-1:0] EV_REGD    = 3'd2;
    localparam logic [KindW-1:0] EV_UNREGD  = 3'd3;
    localparam logic [KindW-1:0] EV_READY   = 3'd4;

    localparam logic [CfgIdxW-1:0] CFG_RESTART_WINDOW = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_QUICK      = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_EXPECTED_ID    = 2'd2;

    localparam logic [WindowW-1:0] RestartWindowRst = 32'd1000000;
    localparam logic [CountW-1:0]  MaxQuickRst      = 8'd5;
    localparam logic [MsgIdW-1:0]  ExpectedIdRst    = 32'd0;

    typedef struct packed {
        logic [KindW-1:0]  kind;
        logic [NowW-1:0]   now;
        logic              start_ok;
        logic              died_normal;
        logic [MsgIdW-1:0] message_id;
    } event_t;

    typedef struct packed {
        lc_state_t         new_state;
        outcome_t          outcome;
        logic [CountW-1:0] failure_count;
        logic              died_report;
        logic              passed_error;
    } result_t;

    typedef struct packed {
        logic [WindowW-1:0] restart_window;
        logic [CountW-1:0]  max_quick_failures;
        logic [MsgIdW-1:0]  expected_message_id;
    } cfg_t;

endpackage

FILE: hdl/plsup_in_stage.sv
// Input register stage: holds one event request until the decision logic takes it.
// Depends on plsup_pkg.
module plsup_in_stage import plsup_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  event_t in_item,
    input  logic   take,
    output logic   held_valid,
    output event_t held_item
);

    logic   valid_reg, valid_next;
    event_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: hdl/plsup_core.sv
// Lifecycle decision logic and state: lifecycle state, start time, quick-failure count.
// Depends on plsup_pkg.
module plsup_core import plsup_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  event_t  ev,
    input  cfg_t    cfg,
    output result_t result
);

    lc_state_t         state_reg, state_next;
    logic [NowW-1:0]   start_reg, start_next;
    logic [CountW-1:0] count_reg, count_next;

    logic [NowW:0]     diff;
    logic              quick;
    logic [CountW-1:0] bumped;
    logic [CountW-1:0] died_cnt;
    logic              limit_hit;
    logic              legal;

    // borrow out of the subtract means the death predates the start
    assign diff     = {1'b0, ev.now} - {1'b0, start_reg};
    assign quick    = diff[NowW] ||
                      ((diff[NowW-1:WindowW] == '0) && (diff[WindowW-1:0] < cfg.restart_window));
    assign bumped   = (count_reg == CountMax) ? count_reg : count_reg + CountW'(1);
    assign died_cnt = quick ? bumped : '0;
    assign limit_hit = died_cnt >= cfg.max_quick_failures;

    // legality of the event in the current state
    always_comb begin
        legal = 1'b0;
        unique case (ev.kind)
            EV_START:  legal = (state_reg == ST_STOPPED);
            EV_DIED:   legal = (state_reg != ST_STOPPED);
            EV_REGD:   legal = (state_reg == ST_UNREG);
            EV_UNREGD: legal = (state_reg != ST_UNREG);
            EV_READY:  legal = (ev.message_id != '0) &&
                               ((ev.message_id != cfg.expected_message_id) ||
                                (state_reg == ST_UNREG));
            default:   legal = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (ev.kind)
            EV_START:  if (legal) state_next = ev.start_ok ? ST_UNREG : ST_STOPPED;
            EV_DIED:   if (legal) state_next = ST_STOPPED;
            EV_REGD:   if (legal && cfg.expected_message_id == '0) state_next = ST_REG;
            EV_UNREGD: if (legal) state_next = ST_UNREG;
            EV_READY:  if (legal && ev.message_id == cfg.expected_message_id) begin
                state_next = ST_REG;
            end
            default:   state_next = state_reg;
        endcase
    end

    // outputs, count and start time
    always_comb begin
        result.outcome      = OC_ILLEGAL;
        result.died_report  = 1'b0;
        result.passed_error = 1'b0;
        count_next          = count_reg;
        start_next          = start_reg;
        if (legal) begin
            unique case (ev.kind)
                EV_START: begin
                    start_next = ev.now;
                    if (ev.start_ok) begin
                        result.outcome = OC_STATUS;
                    end else begin
                        // failed launch: count cleared by the pause
                        result.passed_error = 1'b1;
                        count_next          = '0;
                        result.outcome      = OC_PAUSE;
                    end
                end
                EV_DIED: begin
                    result.died_report = 1'b1;
                    if (ev.died_normal) begin
                        count_next     = '0;
                        result.outcome = OC_DIED;
                    end else begin
                        result.passed_error = 1'b1;
                        count_next          = limit_hit ? '0 : died_cnt;
                        result.outcome      = limit_hit ? OC_PAUSE : OC_DIED;
                    end
                end
                EV_REGD: begin
                    result.outcome = (cfg.expected_message_id == '0) ? OC_STATUS : OC_NONE;
                end
                EV_UNREGD: begin
                    result.outcome = OC_STATUS;
                end
                EV_READY: begin
                    result.outcome = (ev.message_id != cfg.expected_message_id) ?
                                     OC_TERM : OC_STATUS;
                end
                default: begin
                    result.outcome = OC_ILLEGAL;
                end
            endcase
        end
        result.new_state     = state_next;
        result.failure_count = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_STOPPED;
            start_reg <= '0;
            count_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            start_reg <= start_next;
            count_reg <= count_next;
        end
    end

    a_pause_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.outcome == OC_PAUSE |-> result.failure_count == '0)
        else $error("pause left a nonzero failure count");

    a_died_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.died_report |=> state_reg == ST_STOPPED)
        else $error("died event did not stop the worker");

    a_illegal_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.outcome == OC_ILLEGAL |=>
            state_reg == $past(state_reg) && count_reg == $past(count_reg))
        else $error("illegal event changed state");

    a_term_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.outcome == OC_TERM |=> state_reg == $past(state_reg))
        else $error("terminate request changed state");

endmodule

FILE: hdl/process_lifecycle_supervisor_top.sv
// Top level of the process lifecycle supervisor: config registers, result register.
// Depends on plsup_pkg, plsup_in_stage, plsup_core.
//
//  channel  | direction | fields (lowest bit first)
//  s_axis   | in        | tuser: kind; tdata: now, start_ok, died_normal, message_id
//  m_axis   | out       | tdata: new_state, outcome, failure_count, died_report,
//           |           |        passed_error
//  cfg      | in        | cfg_index selects register, cfg_wdata is the value
//
// One event per cycle sustained while m_axis is ready; from s_axis accept to m_axis valid an
// event passes the input register, then the decision logic into the result register.
// The decision is a 63-bit subtract and compare plus a saturating count update.
// aresetn is synchronous: worker stopped, start time and count zero, config at defaults.
// A stalled m_axis holds its result; one more event waits in the input register.
module process_lifecycle_supervisor_top import plsup_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // now[62:0], start_ok, died_normal, message_id
    input  logic [KindW-1:0]    s_axis_tuser,   // kind
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,   // new_state, outcome, failure_count,
                                                // died_report, passed_error
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata
);

    cfg_t    cfg_reg;
    event_t  in_item, held_item;
    logic    held_valid;
    logic    advance;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;

    assign in_item.kind        = s_axis_tuser;
    assign in_item.now         = s_axis_tdata[62:0];
    assign in_item.start_ok    = s_axis_tdata[63];
    assign in_item.died_normal = s_axis_tdata[64];
    assign in_item.message_id  = s_axis_tdata[96:65];

    assign advance        = held_valid && (!out_valid_reg || m_axis_tready);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.restart_window      <= RestartWindowRst;
            cfg_reg.max_quick_failures  <= MaxQuickRst;
            cfg_reg.expected_message_id <= ExpectedIdRst;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RESTART_WINDOW: cfg_reg.restart_window      <= cfg_wdata;
                CFG_MAX_QUICK:      cfg_reg.max_quick_failures  <= cfg_wdata[CountW-1:0];
                CFG_EXPECTED_ID:    cfg_reg.expected_message_id <= cfg_wdata;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    plsup_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    plsup_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .ev      (held_item),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.passed_error, out_reg.died_report,
                            out_reg.failure_count, out_reg.outcome, out_reg.new_state};

endmodule

FILE: test/tb_lifecycle_checker.sv
// Checker for the process lifecycle supervisor: follows the register port and both
// streams, predicts the result of every accepted event and compares it field by field.
// Depends on plsup_pkg only.
module tb_lifecycle_checker import plsup_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,
    input  logic [KindW-1:0]    s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [OutDataW-1:0] m_axis_tdata,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    output int                  mismatches,
    output int                  outstanding
);

    // at most two requests are in flight in the block; the ring has slack to spare
    localparam int RingAw    = 3;
    localparam int RingDepth = 1 << RingAw;

    logic [WindowW-1:0] window_cfg;
    logic [CountW-1:0]  limit_cfg;
    logic [MsgIdW-1:0]  ready_id_cfg;

    lc_state_t          worker_state;
    logic [NowW-1:0]    launch_time;
    logic [CountW-1:0]  quick_count;

    result_t            awaited_ring[RingDepth];
    logic [RingAw-1:0]  ring_wr_ptr;
    logic [RingAw-1:0]  ring_rd_ptr;
    int                 ring_count = 0;
    int                 fail_total = 0;

    // Applies one event to the predicted worker state and returns its result.
    function automatic result_t supervise_event(input logic [KindW-1:0]  kind,
                                                input logic [NowW-1:0]   stamp,
                                                input logic              launch_ok,
                                                input logic              exit_normal,
                                                input logic [MsgIdW-1:0] msg_id);
        result_t r;
        logic    quick;
        r.outcome      = OC_ILLEGAL;
        r.died_report  = 1'b0;
        r.passed_error = 1'b0;
        case (kind)
            EV_START: begin
                if (worker_state == ST_STOPPED) begin
                    launch_time = stamp;
                    if (launch_ok) begin
                        worker_state = ST_UNREG;
                        r.outcome    = OC_STATUS;
                    end else begin
                        // count is cleared by the pause
                        r.passed_error = 1'b1;
                        quick_count    = '0;
                        r.outcome      = OC_PAUSE;
                    end
                end
            end
            EV_DIED: begin
                if (worker_state == ST_UNREG || worker_state == ST_REG) begin
                    r.died_report = 1'b1;
                    worker_state  = ST_STOPPED;
                    if (exit_normal) begin
                        quick_count = '0;
                        r.outcome   = OC_DIED;
                    end else begin
                        r.passed_error = 1'b1;
                        // a stamp below the launch time counts as negative run time
                        quick = (stamp < launch_time) ||
                                ((stamp - launch_time) < NowW'(window_cfg));
                        if (quick) begin
                            if (quick_count != CountMax)
                                quick_count = quick_count + 1'b1;
                        end else begin
                            quick_count = '0;
                        end
                        if (quick_count >= limit_cfg) begin
                            quick_count = '0;
                            r.outcome   = OC_PAUSE;
                        end else begin
                            r.outcome = OC_DIED;
                        end
                    end
                end
            end
            EV_REGD: begin
                if (worker_state == ST_UNREG) begin
                    if (ready_id_cfg == '0) begin
                        worker_state = ST_REG;
                        r.outcome    = OC_STATUS;
                    end else begin
                        r.outcome = OC_NONE;
                    end
                end
            end
            EV_UNREGD: begin
                if (worker_state == ST_STOPPED || worker_state == ST_REG) begin
                    worker_state = ST_UNREG;
                    r.outcome    = OC_STATUS;
                end
            end
            EV_READY: begin
                // id mismatch wins over the state check
                if (msg_id != '0) begin
                    if (msg_id != ready_id_cfg) begin
                        r.outcome = OC_TERM;
                    end else if (worker_state == ST_UNREG) begin
                        worker_state = ST_REG;
                        r.outcome    = OC_STATUS;
                    end
                end
            end
            default: ;
        endcase
        r.new_state     = worker_state;
        r.failure_count = quick_count;
        return r;
    endfunction

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            fail_total++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            window_cfg   = RestartWindowRst;
            limit_cfg    = MaxQuickRst;
            ready_id_cfg = ExpectedIdRst;
            worker_state = ST_STOPPED;
            launch_time  = '0;
            quick_count  = '0;
            ring_wr_ptr  = '0;
            ring_rd_ptr  = '0;
            ring_count   = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_RESTART_WINDOW: window_cfg   = cfg_wdata[WindowW-1:0];
                    CFG_MAX_QUICK:      limit_cfg    = cfg_wdata[CountW-1:0];
                    CFG_EXPECTED_ID:    ready_id_cfg = cfg_wdata[MsgIdW-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (ring_count == RingDepth) begin
                    $display("%0t: requests in flight, expected at most %0d, got %0d",
                             $time, RingDepth, ring_count + 1);
                    fail_total++;
                end else begin
                    awaited_ring[ring_wr_ptr] = supervise_event(s_axis_tuser,
                                                                s_axis_tdata[NowW-1:0],
                                                                s_axis_tdata[NowW],
                                                                s_axis_tdata[NowW+1],
                                                                s_axis_tdata[NowW+2 +: MsgIdW]);
                    ring_wr_ptr = ring_wr_ptr + 1'b1;
                    ring_count++;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (ring_count == 0) begin
                    $display("%0t: result with nothing awaited, expected none, got %h",
                             $time, m_axis_tdata);
                    fail_total++;
                end else begin
                    want        = awaited_ring[ring_rd_ptr];
                    ring_rd_ptr = ring_rd_ptr + 1'b1;
                    ring_count--;
                    check_field("new_state", want.new_state, m_axis_tdata[1:0]);
                    check_field("outcome", want.outcome, m_axis_tdata[4:2]);
                    check_field("failure_count", want.failure_count, m_axis_tdata[12:5]);
                    check_field("died_report", want.died_report, m_axis_tdata[13]);
                    check_field("passed_error", want.passed_error, m_axis_tdata[14]);
                end
            end
        end
        mismatches  <= fail_total;
        outstanding <= ring_count;
    end

endmodule

FILE: test/tb_top.sv
// Testbench top for the process lifecycle supervisor: clock, reset, register writes,
// event stimulus and result backpressure. Depends on plsup_pkg, the block and
// tb_lifecycle_checker.
module tb_top;
    import plsup_pkg::*;

    localparam int CycleLimit = 200000;

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;
    logic [KindW-1:0]    s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                cfg_wr_en;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_wdata;

    int                  mismatches;
    int                  outstanding;

    int                  send_idle_pct;
    int                  ready_stall_pct;
    int                  items_sent;
    int                  cycle_count;
    logic [NowW-1:0]     clock_ts;
    logic [NowW-1:0]     last_launch;
    logic [WindowW-1:0]  window_now;
    logic [MsgIdW-1:0]   ready_id_now;

    process_lifecycle_supervisor_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    tb_lifecycle_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("process_lifecycle_supervisor_top: mismatch");
        $finish;
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end

    function automatic logic [NowW-1:0] rand_stamp();
        return NowW'({$urandom(), $urandom()});
    endfunction

    function automatic logic [NowW-1:0] launch_stamp();
        if ($urandom_range(0, 19) == 0)
            clock_ts = rand_stamp();
        else
            clock_ts = clock_ts + $urandom_range(0, 5000);
        last_launch = clock_ts;
        return clock_ts;
    endfunction

    // Run times clustered around the restart window, plus the odd stamp below launch.
    function automatic logic [NowW-1:0] death_stamp();
        logic [NowW-1:0] stamp;
        case ($urandom_range(0, 9))
            0: stamp = last_launch;
            1: stamp = last_launch + window_now - 1;
            2: stamp = last_launch + window_now;
            3: stamp = last_launch + window_now + 1;
            4: stamp = last_launch + rand_stamp();
            5: stamp = (last_launch == '0) ? '0 : rand_stamp() % last_launch;
            default: stamp = last_launch + $urandom_range(0, window_now);
        endcase
        if (stamp > clock_ts)
            clock_ts = stamp;
        return stamp;
    endfunction

    function automatic logic [MsgIdW-1:0] pick_ready_id();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return ready_id_now;
        if (roll < 85)
            return '0;
        return $urandom();
    endfunction

    // One request on the event stream; returns at the edge where it is taken.
    task automatic send_event(input logic [KindW-1:0]  kind,
                              input logic [NowW-1:0]   stamp,
                              input logic              launch_ok,
                              input logic              exit_normal,
                              input logic [MsgIdW-1:0] msg_id);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(InDataW-NowW-2-MsgIdW){1'b0}}, msg_id, exit_normal,
                          launch_ok, stamp};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        // idle margin after the last result; no event is still in flight here
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Start, a few registration events, then a death.
    task automatic lifecycle_episode();
        int extra;
        send_event(EV_START, launch_stamp(), $urandom_range(0, 9) != 0,
                   $urandom_range(0, 1), $urandom());
        extra = $urandom_range(0, 3);
        repeat (extra) begin
            case ($urandom_range(0, 2))
                0: send_event(EV_UNREGD, rand_stamp(), $urandom_range(0, 1),
                              $urandom_range(0, 1), $urandom());
                1: send_event(EV_REGD, rand_stamp(), $urandom_range(0, 1),
                              $urandom_range(0, 1), $urandom());
                default: send_event(EV_READY, rand_stamp(), $urandom_range(0, 1),
                                    $urandom_range(0, 1), pick_ready_id());
            endcase
        end
        send_event(EV_DIED, death_stamp(), $urandom_range(0, 1),
                   $urandom_range(0, 3) == 0, $urandom());
    endtask

    initial begin
        int target;
        logic [NowW-1:0] stamp_max;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= '0;
        cfg_wdata     <= '0;
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        items_sent      = 0;
        clock_ts        = '0;
        last_launch     = '0;
        window_now      = RestartWindowRst;
        ready_id_now    = ExpectedIdRst;
        stamp_max       = '1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default registers, worker stopped
        send_event(EV_DIED, stamp_max, 1'b1, 1'b1, '1);          // died while stopped
        send_event(EV_REGD, stamp_max, 1'b1, 1'b1, '1);          // registered while stopped
        send_event(EV_READY, '0, 1'b0, 1'b0, '0);                // empty readiness id
        send_event(EV_READY, '0, 1'b0, 1'b0, '1);                // wrong id
        send_event(3'd5, stamp_max, 1'b1, 1'b1, '1);
        send_event(3'd6, '0, 1'b0, 1'b0, '0);
        send_event(3'd7, stamp_max, 1'b1, 1'b1, '1);
        send_event(EV_UNREGD, '0, 1'b0, 1'b0, '0);               // unregistered from stopped
        send_event(EV_UNREGD, '0, 1'b0, 1'b0, '0);               // already unregistered
        send_event(EV_START, stamp_max, 1'b1, 1'b0, '0);         // start while running
        send_event(EV_REGD, '0, 1'b0, 1'b0, '0);
        send_event(EV_READY, '0, 1'b0, 1'b0, 32'h1);             // wrong id while registered
        send_event(EV_UNREGD, '0, 1'b0, 1'b0, '0);
        send_event(EV_DIED, '0, 1'b0, 1'b1, '0);                 // normal exit
        send_event(EV_START, stamp_max, 1'b0, 1'b1, '1);         // failed launch
        send_event(EV_START, stamp_max, 1'b1, 1'b0, '0);
        send_event(EV_DIED, 63'd5, 1'b0, 1'b0, '0);              // stamp below launch
        send_event(EV_START, 63'd100, 1'b1, 1'b0, '0);
        send_event(EV_DIED, 63'd1000099, 1'b0, 1'b0, '0);        // just inside window
        send_event(EV_START, 63'd2000000, 1'b1, 1'b0, '0);
        send_event(EV_DIED, 63'd3000000, 1'b0, 1'b0, '0);        // exactly the window
        send_event(EV_START, '0, 1'b1, 1'b1, '1);
        send_event(EV_DIED, '0, 1'b1, 1'b0, '1);
        clock_ts = 63'd3000000;

        for (int p = 0; p < 6; p++) begin
            drain_results();
            case (p)
                0: begin window_now = 32'd1000;        ready_id_now = '0; end
                1: begin window_now = '0;              ready_id_now = '1; end
                2: begin window_now = '1;              ready_id_now = '0; end
                3: begin window_now = 32'd50000;       ready_id_now = $urandom() | 32'h1; end
                4: begin window_now = $urandom_range(1, 2000000); ready_id_now = 32'h1; end
                default: begin window_now = RestartWindowRst; ready_id_now = 32'h8000_0000; end
            endcase
            write_reg(CFG_RESTART_WINDOW, window_now);
            case (p)
                0: write_reg(CFG_MAX_QUICK, CfgDataW'(1));
                1: write_reg(CFG_MAX_QUICK, CfgDataW'(3));
                2: write_reg(CFG_MAX_QUICK, CfgDataW'(CountMax));
                3: write_reg(CFG_MAX_QUICK, CfgDataW'(4));
                4: write_reg(CFG_MAX_QUICK, CfgDataW'(0));
                default: write_reg(CFG_MAX_QUICK, CfgDataW'(2));
            endcase
            write_reg(CFG_EXPECTED_ID, ready_id_now);
            case (p % 4)
                0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
                1: begin send_idle_pct = 62; ready_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  ready_stall_pct = 62; end
                default: begin send_idle_pct = 9; ready_stall_pct = 9; end
            endcase

            if (p == 2) begin
                // unbroken run of quick abnormal deaths up to the top of the count
                repeat (258) begin
                    send_event(EV_START, launch_stamp(), 1'b1, $urandom_range(0, 1),
                               $urandom());
                    send_event(EV_DIED, last_launch + $urandom_range(0, 32'hFFFF_FFFE),
                               $urandom_range(0, 1), 1'b0, $urandom());
                end
            end else begin
                target = items_sent + 150;
                while (items_sent < target) begin
                    if ($urandom_range(0, 99) < 8)
                        send_event($urandom_range(0, 7), rand_stamp(), $urandom_range(0, 1),
                                   $urandom_range(0, 1), $urandom());
                    else
                        lifecycle_episode();
                end
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("process_lifecycle_supervisor_top: match");
        else
            $display("process_lifecycle_supervisor_top: mismatch");
        $finish;
    end

endmodule
